// File: hw/rtl/cqe_pkg.sv
// cqe_pkg: shared constants and types of the circular queue engine
// no dependencies; used by the interfaces, cqe_ctrl and the top level

package cqe_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STAT_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_SHOW = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_ENQ  = 3'd0,
    STAT_DEQ  = 3'd1,
    STAT_SHOW = 3'd2,
    STAT_OVF  = 3'd3,
    STAT_UNF  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SHOW
  } state_e;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [DATA_W-1:0] word_t;

endpackage

// File: hw/rtl/cqe_if.sv
// cqe_req_if and cqe_rsp_if: valid/ready channels of the queue engine
// depends on cqe_pkg

interface cqe_req_if;
  import cqe_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  word_t             data_in;

  modport source (output valid, output kind, output data_in, input ready);
  modport sink   (input valid, input kind, input data_in, output ready);
endinterface

interface cqe_rsp_if;
  import cqe_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  word_t             data_out;
  logic              last;

  modport source (output valid, output status, output data_out, output last, input ready);
  modport sink   (input valid, input status, input data_out, input last, output ready);
endinterface

// File: hw/rtl/cqe_ram.sv
// cqe_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies

module cqe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/cqe_ctrl.sv
// cqe_ctrl: head/tail pointers, request sequencer and result register
// depends on cqe_pkg and cqe_if; drives the slot ram ports

module cqe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cqe_req_if.sink              req_i,
  cqe_rsp_if.source            rsp_o,
  output logic                 ram_we_o,
  output cqe_pkg::idx_t        ram_waddr_o,
  output cqe_pkg::word_t       ram_wdata_o,
  output logic                 ram_re_o,
  output cqe_pkg::idx_t        ram_raddr_o,
  input  cqe_pkg::word_t       ram_rdata_i
);
  import cqe_pkg::*;

  function automatic idx_t next_idx(input idx_t i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  state_e  state_q, state_d;
  idx_t    head_q, head_d;
  idx_t    tail_q, tail_d;
  logic    empty_q, empty_d;
  idx_t    walk_q, walk_d;

  logic    out_valid_q, out_valid_d;
  status_e out_status_q, out_status_d;
  word_t   out_data_q, out_data_d;
  logic    out_last_q, out_last_d;

  logic    out_free;
  logic    req_fire;
  logic    full;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign req_fire    = req_i.valid && req_i.ready;
  assign full        = !empty_q && (next_idx(tail_q) == head_q);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    empty_d      = empty_q;
    walk_d       = walk_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = tail_q;
    ram_wdata_o  = req_i.data_in;
    ram_re_o     = 1'b0;
    ram_raddr_o  = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          unique case (req_i.kind)
            KIND_ENQ: begin
              out_valid_d  = 1'b1;
              out_data_d   = '0;
              out_last_d   = 1'b1;
              if (empty_q) begin
                head_d       = '0;
                tail_d       = '0;
                empty_d      = 1'b0;
                ram_we_o     = 1'b1;
                ram_waddr_o  = '0;
                out_status_d = STAT_ENQ;
              end else if (full) begin
                out_status_d = STAT_OVF;
              end else begin
                tail_d       = next_idx(tail_q);
                ram_we_o     = 1'b1;
                ram_waddr_o  = next_idx(tail_q);
                out_status_d = STAT_ENQ;
              end
            end
            KIND_DEQ: begin
              if (empty_q) begin
                out_valid_d  = 1'b1;
                out_status_d = STAT_UNF;
                out_data_d   = '0;
                out_last_d   = 1'b1;
              end else begin
                ram_re_o = 1'b1;
                state_d  = S_DEQ;
                if (head_q == tail_q) begin
                  empty_d = 1'b1;
                  head_d  = '0;
                  tail_d  = '0;
                end else begin
                  head_d = next_idx(head_q);
                end
              end
            end
            KIND_SHOW: begin
              if (empty_q) begin
                out_valid_d  = 1'b1;
                out_status_d = STAT_UNF;
                out_data_d   = '0;
                out_last_d   = 1'b1;
              end else begin
                ram_re_o = 1'b1;
                walk_d   = head_q;
                state_d  = S_SHOW;
              end
            end
            KIND_NONE: begin
              state_d = S_IDLE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_DEQ: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_DEQ;
          out_data_d   = ram_rdata_i;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SHOW: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_SHOW;
          out_data_d   = ram_rdata_i;
          out_last_d   = (walk_q == tail_q);
          if (walk_q == tail_q) begin
            state_d = S_IDLE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = next_idx(walk_q);
            walk_d      = next_idx(walk_q);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q       <= walk_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.data_out = out_data_q;
  assign rsp_o.last     = out_last_q;

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("slot ram read and write in the same cycle");

  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0 && tail_q == '0))
    else $error("empty queue with nonzero pointers");

  a_busy_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_i.ready)
    else $error("request taken while a walk or read is pending");

  a_enq_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.kind == KIND_ENQ) |=> (out_valid_q && out_last_q))
    else $error("enqueue request gave no result");

  a_walk_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHOW) |-> !empty_q)
    else $error("display walk on an empty queue");

endmodule

// File: hw/rtl/circular_queue_engine_core.sv
// circular_queue_engine_core: top level of the circular queue engine
// depends on cqe_pkg, cqe_if, cqe_ram and cqe_ctrl
//
// A ring buffer of DEPTH signed 32-bit words held in one synchronous ram with
// a registered read. Enqueue, and any overflow or underflow response, goes
// straight to the output register; dequeue passes the ram read register first.
// Display reads one slot per cycle unless the response channel stalls;
// requests are held off until its last result is in the output register.
// Results wait in a single output register, and a stalled response channel
// stalls the engine. Request code 3 is dropped with no response.

module circular_queue_engine_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  cqe_req_if.sink   req_i,
  cqe_rsp_if.source rsp_o
);
  import cqe_pkg::*;

  logic  ram_we;
  idx_t  ram_waddr;
  word_t ram_wdata;
  logic  ram_re;
  idx_t  ram_raddr;
  word_t ram_rdata;

  cqe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  cqe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
